### rtl/core/ans_pkg.sv
// Shared definitions for the audio note segmenter.
// Holds register indexes, field widths and the controller/datapath handshake structs.
// No dependencies.
package ans_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_PITCH_CENTER      = 3'd0;
  localparam logic [2:0] REG_PITCH_HALF_WINDOW = 3'd1;
  localparam logic [2:0] REG_PEAK_THRESHOLD    = 3'd2;
  localparam logic [2:0] REG_PITCH_TOLERANCE   = 3'd3;
  localparam logic [2:0] REG_POWER_TOLERANCE   = 3'd4;
  localparam logic [2:0] REG_MIN_NOTE_FRAMES   = 3'd5;
  localparam logic [2:0] REG_ATTACK_FRAMES     = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Field widths.
  localparam int LOC_W   = 32;
  localparam int PWR_W   = 16;
  localparam int TONE_W  = 16;
  localparam int PITCH_W = 16;
  localparam int PEAK_W  = 24;
  localparam int ONSET_W = 16;
  localparam int FRM_W   = 32;
  localparam int CNT12_W = 12;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // an input transaction completes this cycle
    logic step;      // run one divider iteration
    logic load_out;  // move the finished result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;      // the frame being offered closes a note that is long enough
    logic div_last;  // the divider is on its final iteration
  } status_t;

endpackage

### rtl/core/audio_note_segmenter.sv
// Audio note segmenter: cuts a stream of feature frames into note records.
// Top level; instantiates ans_ctrl and ans_dp and uses ans_pkg.
//
// Use: frames enter on the in channel (in_valid/in_ready), one transaction per
// frame. Each frame updates the note state in the cycle it is accepted. A frame
// that closes a note longer than min_note_frames produces one note record on the
// out channel (out_valid/out_ready); every other frame produces nothing.
// Configuration is written through cfg_we/cfg_index/cfg_data while the block is
// idle; a write takes effect at once, and indexes beyond the list are ignored.
// A frame that does not emit leaves the block idle and ready for the next frame.
// A frame that emits occupies the block while the bit-serial divider forms the
// mean tone and mean peakiness; the record then waits in the final state until
// the output register is free, and no frame is accepted until it is loaded.
// The finished record sits in an output register, so new frames are accepted
// while it waits. If the receiver stalls and a second record is ready, the block
// holds that record and stops accepting frames until the first one is taken.
// Reset (synchronous, active high) restores the default configuration, clears
// the note state and the frame counter, and drops out_valid.
module audio_note_segmenter
  import ans_pkg::*;
#(
  parameter int MAX_NOTE_FRAMES = 4095
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [LOC_W-1:0]      sample_location,
  input  logic [PWR_W-1:0]      frame_power,
  input  logic [TONE_W-1:0]     frame_tone,
  input  logic [PITCH_W-1:0]    frame_pitch,
  input  logic [PEAK_W-1:0]     frame_peakiness,
  input  logic [ONSET_W-1:0]    frame_onset,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FRM_W-1:0]      start_frame,
  output logic [LOC_W-1:0]      end_sample,
  output logic [PITCH_W-1:0]    note_pitch_hz,
  output logic [CNT12_W-1:0]    length_frames,
  output logic [PWR_W-1:0]      note_rms,
  output logic [TONE_W-1:0]     mean_tone,
  output logic [ONSET_W-1:0]    note_onset,
  output logic [PEAK_W-1:0]     mean_peakiness
);

  cmd_t    cmd;
  status_t status;

  // The controller owns the handshakes and the divide sequence.
  ans_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds configuration, note state, the divider and the result.
  ans_dp #(
    .MAX_NOTE_FRAMES (MAX_NOTE_FRAMES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sample_location (sample_location),
    .frame_power     (frame_power),
    .frame_tone      (frame_tone),
    .frame_pitch     (frame_pitch),
    .frame_peakiness (frame_peakiness),
    .frame_onset     (frame_onset),
    .cmd             (cmd),
    .status          (status),
    .start_frame     (start_frame),
    .end_sample      (end_sample),
    .note_pitch_hz   (note_pitch_hz),
    .length_frames   (length_frames),
    .note_rms        (note_rms),
    .mean_tone       (mean_tone),
    .note_onset      (note_onset),
    .mean_peakiness  (mean_peakiness)
  );

endmodule

### rtl/core/ans_ctrl.sv
// Controller state machine of the audio note segmenter.
// Sequences input acceptance, the serial divide and the output register; uses ans_pkg.
module ans_ctrl
  import ans_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd.accept   = accept;
    cmd.step     = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && status.emit) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  // A frame that emits starts the divider on the next cycle.
  a_emit_divides: assert property (@(posedge clk) disable iff (rst)
    (accept && status.emit) |=> (state == S_DIV))
    else $error("emitting frame did not start the divider");

  // A loaded result is presented on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

endmodule

### rtl/core/ans_dp.sv
// Datapath of the audio note segmenter: configuration, note state, serial divider, output.
// Driven by ans_ctrl through cmd_t/status_t; uses ans_pkg.
module ans_dp
  import ans_pkg::*;
#(
  parameter int MAX_NOTE_FRAMES = 4095
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [LOC_W-1:0]      sample_location,
  input  logic [PWR_W-1:0]      frame_power,
  input  logic [TONE_W-1:0]     frame_tone,
  input  logic [PITCH_W-1:0]    frame_pitch,
  input  logic [PEAK_W-1:0]     frame_peakiness,
  input  logic [ONSET_W-1:0]    frame_onset,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic [FRM_W-1:0]      start_frame,
  output logic [LOC_W-1:0]      end_sample,
  output logic [PITCH_W-1:0]    note_pitch_hz,
  output logic [CNT12_W-1:0]    length_frames,
  output logic [PWR_W-1:0]      note_rms,
  output logic [TONE_W-1:0]     mean_tone,
  output logic [ONSET_W-1:0]    note_onset,
  output logic [PEAK_W-1:0]     mean_peakiness
);

  localparam int LEN_W   = $clog2(MAX_NOTE_FRAMES + 1);
  localparam int CMP_W   = (LEN_W > CNT12_W) ? LEN_W : CNT12_W;
  localparam int TSUM_W  = TONE_W + LEN_W;
  localparam int PSUM_W  = PEAK_W + LEN_W;
  localparam int STEPS   = PSUM_W;
  localparam int STEP_W  = $clog2(STEPS);
  localparam int NEAR_W  = PITCH_W + 1;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_NOTE_FRAMES);

  // Configuration registers.
  logic [PITCH_W-1:0] pitch_center;
  logic [PITCH_W-1:0] pitch_half_window;
  logic [PEAK_W-1:0]  peak_threshold;
  logic [PITCH_W-1:0] pitch_tolerance;
  logic [PWR_W-1:0]   power_tolerance;
  logic [CNT12_W-1:0] min_note_frames;
  logic [CNT12_W-1:0] attack_frames;

  // Note state.
  logic               in_note;
  logic [FRM_W-1:0]   frame_counter;
  logic [LEN_W-1:0]   note_length;
  logic [PITCH_W-1:0] held_pitch;
  logic [PWR_W-1:0]   held_power;
  logic [ONSET_W-1:0] held_onset;
  logic [TSUM_W-1:0]  tone_sum;
  logic [PSUM_W-1:0]  peakiness_sum;

  // Fields of the closing frame, held while the divider runs.
  logic [FRM_W-1:0]   pend_start;
  logic [LOC_W-1:0]   pend_end;
  logic [PITCH_W-1:0] pend_pitch;
  logic [CNT12_W-1:0] pend_len;
  logic [PWR_W-1:0]   pend_rms;
  logic [ONSET_W-1:0] pend_onset;

  // Serial divider: both sums share one divisor and one iteration counter.
  logic [LEN_W-1:0]   div_den;
  logic [PSUM_W-1:0]  div_pk;
  logic [PSUM_W-1:0]  div_tn;
  logic [LEN_W-1:0]   pk_rem;
  logic [LEN_W-1:0]   tn_rem;
  logic [STEP_W-1:0]  div_cnt;

  logic               in_window;
  logic               peaky;
  logic               near_pitch;
  logic               near_power;
  logic               extend;
  logic               closes;
  logic               emit;
  logic [LEN_W-1:0]   len_inc;
  logic               len_room;
  logic               drop_power;
  logic [FRM_W-1:0]   len_m1_ext;

  logic [LEN_W:0]     pk_shift;
  logic [LEN_W+1:0]   pk_diff;
  logic               pk_ge;
  logic [LEN_W:0]     tn_shift;
  logic [LEN_W+1:0]   tn_diff;
  logic               tn_ge;

  // v lies strictly between c - d and c + d, evaluated without wrap.
  function automatic logic strictly_near(input logic [PITCH_W-1:0] v,
                                         input logic [PITCH_W-1:0] c,
                                         input logic [PITCH_W-1:0] d);
    logic [NEAR_W-1:0] vd;
    logic [NEAR_W-1:0] cd;
    vd = NEAR_W'(v) + NEAR_W'(d);
    cd = NEAR_W'(c) + NEAR_W'(d);
    return (vd > NEAR_W'(c)) && (NEAR_W'(v) < cd);
  endfunction

  always_comb begin
    in_window  = strictly_near(frame_pitch, pitch_center, pitch_half_window);
    peaky      = frame_peakiness > peak_threshold;
    near_pitch = strictly_near(frame_pitch, held_pitch, pitch_tolerance);
    near_power = strictly_near(frame_power, held_power, power_tolerance);
    extend     = in_window && in_note && near_pitch && peaky && near_power;
    closes     = in_window && in_note && !(near_pitch && peaky && near_power);
    emit       = closes && (CMP_W'(note_length) > CMP_W'(min_note_frames))
                 && (note_length != '0);
    len_room   = note_length < LEN_MAX;
    len_inc    = len_room ? (note_length + LEN_W'(1)) : note_length;
    drop_power = (CMP_W'(len_inc) < CMP_W'(attack_frames)) && (frame_power < held_power);
    len_m1_ext = FRM_W'(note_length) - FRM_W'(1);
  end

  assign status.emit     = emit;
  assign status.div_last = (div_cnt == '0);

  always_comb begin
    pk_shift = {pk_rem, div_pk[PSUM_W-1]};
    pk_diff  = {1'b0, pk_shift} - {2'b00, div_den};
    pk_ge    = !pk_diff[LEN_W+1];
    tn_shift = {tn_rem, div_tn[PSUM_W-1]};
    tn_diff  = {1'b0, tn_shift} - {2'b00, div_den};
    tn_ge    = !tn_diff[LEN_W+1];
  end

  // Configuration and note state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_center      <= '0;
      pitch_half_window <= 16'hFFFF;
      peak_threshold    <= 24'd12000;
      pitch_tolerance   <= 16'd32;
      power_tolerance   <= 16'd5898;
      min_note_frames   <= 12'd10;
      attack_frames     <= 12'd4;
      in_note           <= 1'b0;
      frame_counter     <= '0;
      note_length       <= '0;
      held_pitch        <= '0;
      held_power        <= '0;
      held_onset        <= '0;
      tone_sum          <= '0;
      peakiness_sum     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PITCH_CENTER:      pitch_center      <= cfg_data[PITCH_W-1:0];
          REG_PITCH_HALF_WINDOW: pitch_half_window <= cfg_data[PITCH_W-1:0];
          REG_PEAK_THRESHOLD:    peak_threshold    <= cfg_data[PEAK_W-1:0];
          REG_PITCH_TOLERANCE:   pitch_tolerance   <= cfg_data[PITCH_W-1:0];
          REG_POWER_TOLERANCE:   power_tolerance   <= cfg_data[PWR_W-1:0];
          REG_MIN_NOTE_FRAMES:   min_note_frames   <= cfg_data[CNT12_W-1:0];
          REG_ATTACK_FRAMES:     attack_frames     <= cfg_data[CNT12_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.accept) begin
        frame_counter <= frame_counter + FRM_W'(1);
        if (extend) begin
          note_length <= len_inc;
          if (len_room) begin
            tone_sum      <= tone_sum + TSUM_W'(frame_tone);
            peakiness_sum <= peakiness_sum + PSUM_W'(frame_peakiness);
          end
          if (drop_power) begin
            held_power <= frame_power;
          end
        end else if (closes) begin
          in_note       <= 1'b0;
          note_length   <= '0;
          tone_sum      <= '0;
          peakiness_sum <= '0;
        end else if (in_window && !in_note && peaky) begin
          in_note     <= 1'b1;
          note_length <= LEN_W'(1);
          held_pitch  <= frame_pitch;
          held_power  <= frame_power;
          held_onset  <= frame_onset;
        end
      end
    end
  end

  // Pending result, divider and output register.
  always_ff @(posedge clk) begin
    if (cmd.accept && emit) begin
      pend_start <= frame_counter - FRM_W'(note_length);
      pend_end   <= sample_location;
      pend_pitch <= held_pitch;
      pend_len   <= len_m1_ext[CNT12_W-1:0];
      pend_rms   <= held_power;
      pend_onset <= held_onset;
      div_den    <= note_length;
      div_pk     <= peakiness_sum;
      div_tn     <= PSUM_W'(tone_sum);
      pk_rem     <= '0;
      tn_rem     <= '0;
      div_cnt    <= STEP_W'(STEPS - 1);
    end else if (cmd.step) begin
      div_pk  <= {div_pk[PSUM_W-2:0], pk_ge};
      div_tn  <= {div_tn[PSUM_W-2:0], tn_ge};
      pk_rem  <= pk_ge ? pk_diff[LEN_W-1:0] : pk_shift[LEN_W-1:0];
      tn_rem  <= tn_ge ? tn_diff[LEN_W-1:0] : tn_shift[LEN_W-1:0];
      div_cnt <= div_cnt - STEP_W'(1);
    end
    if (cmd.load_out) begin
      start_frame    <= pend_start;
      end_sample     <= pend_end;
      note_pitch_hz  <= pend_pitch;
      length_frames  <= pend_len;
      note_rms       <= pend_rms;
      mean_tone      <= div_tn[TONE_W-1:0];
      note_onset     <= pend_onset;
      mean_peakiness <= div_pk[PEAK_W-1:0];
    end
  end

  // The divisor is a closed note's length and so never zero.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (div_den != '0))
    else $error("divider running with a zero divisor");

  // The note length saturates and never passes the limit.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    note_length <= LEN_MAX)
    else $error("note length above its limit");

  // Outside a note the length and both sums stay cleared.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !in_note |-> (note_length == '0 && tone_sum == '0 && peakiness_sum == '0))
    else $error("note state not cleared outside a note");

endmodule

### tb/audio_note_segmenter_checker.sv
// Passive checker for the audio note segmenter: follows register writes and frame
// transactions, predicts note records and compares them with the out channel.
// Depends on ans_pkg for field widths and register indexes.
module audio_note_segmenter_checker
  import ans_pkg::*;
#(
  parameter int MAX_NOTE_FRAMES = 4095
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [LOC_W-1:0]      sample_location,
  input  logic [PWR_W-1:0]      frame_power,
  input  logic [TONE_W-1:0]     frame_tone,
  input  logic [PITCH_W-1:0]    frame_pitch,
  input  logic [PEAK_W-1:0]     frame_peakiness,
  input  logic [ONSET_W-1:0]    frame_onset,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [FRM_W-1:0]      start_frame,
  input  logic [LOC_W-1:0]      end_sample,
  input  logic [PITCH_W-1:0]    note_pitch_hz,
  input  logic [CNT12_W-1:0]    length_frames,
  input  logic [PWR_W-1:0]      note_rms,
  input  logic [TONE_W-1:0]     mean_tone,
  input  logic [ONSET_W-1:0]    note_onset,
  input  logic [PEAK_W-1:0]     mean_peakiness,
  output int                    mismatch_count,
  output int                    notes_awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [FRM_W-1:0]   start_frame;
    logic [LOC_W-1:0]   end_sample;
    logic [PITCH_W-1:0] note_pitch_hz;
    logic [CNT12_W-1:0] length_frames;
    logic [PWR_W-1:0]   note_rms;
    logic [TONE_W-1:0]  mean_tone;
    logic [ONSET_W-1:0] note_onset;
    logic [PEAK_W-1:0]  mean_peakiness;
  } note_record_t;

  note_record_t awaited_notes[$];

  // Register copies.
  logic [PITCH_W-1:0] win_center, win_half, pitch_tol;
  logic [PWR_W-1:0]   power_tol;
  logic [PEAK_W-1:0]  peak_thr;
  logic [CNT12_W-1:0] min_frames, attack_len;

  // Note tracking state.
  logic               active;
  logic [FRM_W-1:0]   frames_seen;
  logic [15:0]        note_len;
  logic [PITCH_W-1:0] held_pitch;
  logic [PWR_W-1:0]   held_power;
  logic [ONSET_W-1:0] held_onset;
  logic [31:0]        tone_acc;
  logic [39:0]        peak_acc;

  task automatic log_mismatch(input string msg);
    $display("[%0t] note check: %s", $time, msg);
    mismatch_count++;
  endtask

  // Open interval test, done wide so the differences never wrap.
  function automatic bit strictly_near(input longint v, input longint c, input longint d);
    return (v > c - d) && (v < c + d);
  endfunction

  task automatic restore_defaults();
    win_center  = '0;
    win_half    = 16'hFFFF;
    peak_thr    = 24'd12000;
    pitch_tol   = 16'd32;
    power_tol   = 16'd5898;
    min_frames  = 12'd10;
    attack_len  = 12'd4;
    active      = 1'b0;
    frames_seen = '0;
    note_len    = '0;
    held_pitch  = '0;
    held_power  = '0;
    held_onset  = '0;
    tone_acc    = '0;
    peak_acc    = '0;
    awaited_notes.delete();
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_PITCH_CENTER:      win_center = value[PITCH_W-1:0];
      REG_PITCH_HALF_WINDOW: win_half   = value[PITCH_W-1:0];
      REG_PEAK_THRESHOLD:    peak_thr   = value[PEAK_W-1:0];
      REG_PITCH_TOLERANCE:   pitch_tol  = value[PITCH_W-1:0];
      REG_POWER_TOLERANCE:   power_tol  = value[PWR_W-1:0];
      REG_MIN_NOTE_FRAMES:   min_frames = value[CNT12_W-1:0];
      REG_ATTACK_FRAMES:     attack_len = value[CNT12_W-1:0];
      default: ;
    endcase
  endtask

  // Advances the note state by one frame and queues the record it closes, if any.
  task automatic segment_frame(input logic [LOC_W-1:0] loc, input logic [PWR_W-1:0] power,
                               input logic [TONE_W-1:0] tone, input logic [PITCH_W-1:0] pitch,
                               input logic [PEAK_W-1:0] peak, input logic [ONSET_W-1:0] onset);
    note_record_t rec;
    bit peaky, near_pitch, near_power;
    if (strictly_near(pitch, win_center, win_half)) begin
      peaky      = peak > peak_thr;
      near_pitch = strictly_near(pitch, held_pitch, pitch_tol);
      near_power = strictly_near(power, held_power, power_tol);
      if (active) begin
        if (near_pitch && peaky && near_power) begin
          if (note_len < MAX_NOTE_FRAMES) begin
            note_len++;
            tone_acc += tone;
            peak_acc += peak;
          end
          if (note_len < attack_len && power < held_power) held_power = power;
        end else begin
          if (note_len > min_frames && note_len != 0) begin
            rec.start_frame    = frames_seen - note_len;
            rec.end_sample     = loc;
            rec.note_pitch_hz  = held_pitch;
            rec.length_frames  = CNT12_W'(note_len - 16'd1);
            rec.note_rms       = held_power;
            rec.mean_tone      = TONE_W'(tone_acc / note_len);
            rec.note_onset     = held_onset;
            rec.mean_peakiness = PEAK_W'(peak_acc / note_len);
            awaited_notes.insert(awaited_notes.size(), rec);
          end
          active   = 1'b0;
          note_len = '0;
          tone_acc = '0;
          peak_acc = '0;
        end
      end else if (peaky) begin
        // The opening frame counts in the length but stays out of the sums.
        active     = 1'b1;
        note_len   = 16'd1;
        held_pitch = pitch;
        held_power = power;
        held_onset = onset;
      end
    end
    frames_seen++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) log_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  task automatic check_note();
    note_record_t want;
    if (awaited_notes.size() == 0) begin
      log_mismatch("note record arrived while no closed note was outstanding");
    end else begin
      want = awaited_notes.pop_front();
      compare_field("start_frame", start_frame, want.start_frame);
      compare_field("end_sample", end_sample, want.end_sample);
      compare_field("note_pitch_hz", note_pitch_hz, want.note_pitch_hz);
      compare_field("length_frames", length_frames, want.length_frames);
      compare_field("note_rms", note_rms, want.note_rms);
      compare_field("mean_tone", mean_tone, want.mean_tone);
      compare_field("note_onset", note_onset, want.note_onset);
      compare_field("mean_peakiness", mean_peakiness, want.mean_peakiness);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restore_defaults();
    end else begin
      if (cfg_we) write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        segment_frame(sample_location, frame_power, frame_tone, frame_pitch,
                      frame_peakiness, frame_onset);
      end
      if (out_valid && out_ready) check_note();
    end
    notes_awaited = awaited_notes.size();
  end

endmodule

### tb/tb_audio_note_segmenter.sv
// Testbench top for the audio note segmenter: drives frames, register writes and
// back-pressure, and gives the verdict. Depends on ans_pkg, the block and its checker.
module tb_audio_note_segmenter
  import ans_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NOTE_CAP      = 4095;
  localparam int SETTLE_CYCLES = 64;    // covers the divider with margin
  localparam int STALL_LIMIT   = 5000;  // cycles without any transaction
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    int unsigned center;
    int unsigned half;
    int unsigned thr;
    int unsigned ptol;
    int unsigned pwtol;
    int unsigned min_frames;
    int unsigned attack;
  } cfg_set_t;

  typedef struct {
    logic [LOC_W-1:0]   loc;
    logic [PWR_W-1:0]   pwr;
    logic [TONE_W-1:0]  tone;
    logic [PITCH_W-1:0] pitch;
    logic [PEAK_W-1:0]  peak;
    logic [ONSET_W-1:0] onset;
  } frame_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [LOC_W-1:0]      sample_location = '0;
  logic [PWR_W-1:0]      frame_power = '0;
  logic [TONE_W-1:0]     frame_tone = '0;
  logic [PITCH_W-1:0]    frame_pitch = '0;
  logic [PEAK_W-1:0]     frame_peakiness = '0;
  logic [ONSET_W-1:0]    frame_onset = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [FRM_W-1:0]      start_frame;
  logic [LOC_W-1:0]      end_sample;
  logic [PITCH_W-1:0]    note_pitch_hz;
  logic [CNT12_W-1:0]    length_frames;
  logic [PWR_W-1:0]      note_rms;
  logic [TONE_W-1:0]     mean_tone;
  logic [ONSET_W-1:0]    note_onset;
  logic [PEAK_W-1:0]     mean_peakiness;
  int                    mismatch_count;
  int                    notes_awaited;

  // Stimulus shaping: the current register values and the idling percentages.
  cfg_set_t cfg_now;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       quiet_cycles = 0;

  audio_note_segmenter #(.MAX_NOTE_FRAMES(NOTE_CAP)) uut (.*);

  audio_note_segmenter_checker #(.MAX_NOTE_FRAMES(NOTE_CAP)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver decides afresh on every cycle whether to take a note record.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a run that goes quiet for too long has hung somewhere.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 77;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 77;
      end
      default: begin
        send_idle_pct = 13;
        recv_stall_pct = 13;
      end
    endcase
  endtask

  // Offers one frame and returns in the time step of the edge that accepts it.
  // Valid is only dropped when the sender decides to idle, so back-to-back frames
  // keep it high.
  task automatic send_frame(input frame_t f);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    sample_location <= f.loc;
    frame_power     <= f.pwr;
    frame_tone      <= f.tone;
    frame_pitch     <= f.pitch;
    frame_peakiness <= f.peak;
    frame_onset     <= f.onset;
    do @(posedge clk); while (!in_ready);
  endtask

  // Lets every outstanding note record drain, then gives the block time to finish
  // whatever frame it may still be working on.
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (notes_awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  // Writes every register in consecutive cycles, plus one write to an index past
  // the end of the list that the block must ignore.
  task automatic apply_config(input cfg_set_t c);
    cfg_we <= 1'b1;
    put_register(REG_PITCH_CENTER, c.center);
    put_register(REG_PITCH_HALF_WINDOW, c.half);
    put_register(REG_PEAK_THRESHOLD, c.thr);
    put_register(REG_PITCH_TOLERANCE, c.ptol);
    put_register(REG_POWER_TOLERANCE, c.pwtol);
    put_register(REG_MIN_NOTE_FRAMES, c.min_frames);
    put_register(REG_ATTACK_FRAMES, c.attack);
    put_register(REG_UNUSED, $urandom);
    cfg_we <= 1'b0;
    cfg_now = c;
  endtask

  function automatic cfg_set_t random_config();
    cfg_set_t c;
    c.center     = $urandom_range(60000, 2000);
    c.half       = $urandom_range(20000, 500);
    c.thr        = $urandom_range(100000, 0);
    c.ptol       = $urandom_range(400, 1);
    c.pwtol      = $urandom_range(20000, 4);
    c.min_frames = $urandom_range(15, 0);
    c.attack     = $urandom_range(12, 0);
    return c;
  endfunction

  function automatic logic [15:0] clip16(input longint v);
    if (v < 0) return 16'h0000;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // A signed offset in the closed range [-b, b].
  function automatic longint jitter(input int unsigned b);
    return longint'($urandom_range(2 * b, 0)) - longint'(b);
  endfunction

  function automatic frame_t noise_frame();
    frame_t f;
    f.loc   = $urandom;
    f.pwr   = PWR_W'($urandom);
    f.tone  = TONE_W'($urandom);
    f.pitch = PITCH_W'($urandom);
    f.peak  = PEAK_W'($urandom);
    f.onset = ONSET_W'($urandom);
    return f;
  endfunction

  function automatic logic [PITCH_W-1:0] pitch_in_window();
    if (cfg_now.half < 2) return PITCH_W'(cfg_now.center);
    return clip16(longint'(cfg_now.center) + jitter(cfg_now.half - 1));
  endfunction

  function automatic logic [PITCH_W-1:0] pitch_outside();
    if ($urandom_range(1)) begin
      return clip16(longint'(cfg_now.center) + cfg_now.half + $urandom_range(200, 0));
    end
    return clip16(longint'(cfg_now.center) - cfg_now.half - $urandom_range(200, 0));
  endfunction

  function automatic logic [PEAK_W-1:0] peaky_value();
    if (cfg_now.thr >= 24'hFFFFFF) return PEAK_W'($urandom);
    return PEAK_W'($urandom_range(24'hFFFFFF, cfg_now.thr + 1));
  endfunction

  function automatic logic [PEAK_W-1:0] quiet_peak();
    return PEAK_W'($urandom_range(cfg_now.thr, 0));
  endfunction

  // A well-formed note: an opening frame, len-1 frames that should extend it with
  // the odd out-of-window frame mixed in, and one frame that tries to close it.
  // Extension powers stay within a quarter of the tolerance of the opening power,
  // so the attack can pull the held power down without breaking the note.
  task automatic play_note(input int len, inout int sent);
    frame_t f;
    logic [PITCH_W-1:0] p0;
    logic [PWR_W-1:0] w0;
    int unsigned band_p, band_w;
    f = noise_frame();
    f.pitch = pitch_in_window();
    f.peak = peaky_value();
    p0 = f.pitch;
    w0 = f.pwr;
    send_frame(f);
    sent++;
    band_p = (cfg_now.ptol == 0) ? 0 : cfg_now.ptol - 1;
    band_w = cfg_now.pwtol / 4;
    for (int k = 1; k < len; k++) begin
      f = noise_frame();
      if ($urandom_range(29) == 0) begin
        f.pitch = pitch_outside();
      end else begin
        f.pitch = clip16(longint'(p0) + jitter(band_p));
        f.pwr   = clip16(longint'(w0) + jitter(band_w));
        f.peak  = peaky_value();
      end
      send_frame(f);
      sent++;
    end
    f = noise_frame();
    case ($urandom_range(3))
      0: begin
        // Everything matches but the peakiness.
        f.pitch = p0;
        f.pwr   = w0;
        f.peak  = quiet_peak();
      end
      1: begin
        // Pitch off by exactly the tolerance, which the strict test rejects.
        f.pitch = $urandom_range(1) ? clip16(longint'(p0) + cfg_now.ptol)
                                    : clip16(longint'(p0) - cfg_now.ptol);
        f.pwr   = w0;
        f.peak  = peaky_value();
      end
      2: begin
        // Held power never rises above the opening power, so this is out of reach.
        f.pitch = p0;
        f.pwr   = clip16(longint'(w0) + cfg_now.pwtol);
        f.peak  = peaky_value();
      end
      default: f.pitch = pitch_in_window();
    endcase
    send_frame(f);
    sent++;
  endtask

  // Mostly notes with random content, the rest noise, skipped frames and frames
  // sitting exactly on the window edge or the peakiness threshold.
  task automatic run_random(input int quota);
    int sent;
    int lo, hi;
    frame_t f;
    sent = 0;
    while (sent < quota) begin
      case ($urandom_range(9))
        7: begin
          f = noise_frame();
          send_frame(f);
          sent++;
        end
        8: begin
          f = noise_frame();
          f.pitch = pitch_outside();
          send_frame(f);
          sent++;
        end
        9: begin
          f = noise_frame();
          if ($urandom_range(1)) begin
            f.pitch = $urandom_range(1) ? clip16(longint'(cfg_now.center) + cfg_now.half)
                                        : clip16(longint'(cfg_now.center) - cfg_now.half);
          end else begin
            f.pitch = pitch_in_window();
            f.peak  = PEAK_W'(cfg_now.thr);
          end
          send_frame(f);
          sent++;
        end
        default: begin
          // Lengths cluster around the minimum so that notes land on both sides.
          hi = cfg_now.min_frames + 6;
          if (hi > 300) hi = 300;
          lo = (hi > 8) ? hi - 8 : 1;
          if ($urandom_range(3) == 0) play_note($urandom_range(6, 1), sent);
          else play_note($urandom_range(hi, lo), sent);
        end
      endcase
    end
  endtask

  // Directed frames under the reset configuration: window edge, threshold edge,
  // a note that emits after an attack and tolerance-edge extensions, a short note
  // that closes silently, and a note at pitch zero.
  task automatic run_directed();
    frame_t f;
    send_frame('{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 16'hFFFF});
    send_frame('{32'h0, 16'h0, 16'h0, 16'h0, 24'd12000, 16'h0});
    send_frame('{32'd100, 16'd40000, 16'hFFFF, 16'h1000, 24'd12001, 16'hFFFF});
    for (int k = 1; k <= 12; k++) begin
      f.loc   = $urandom;
      f.pwr   = (k <= 3) ? PWR_W'(40000 - 1000 * k) : ((k % 2) ? 16'd43897 : 16'd32103);
      f.tone  = (k % 2) ? 16'hFFFF : 16'h0000;
      f.pitch = (k % 2) ? 16'h1000 + 16'd31 : 16'h1000 - 16'd31;
      f.peak  = (k % 2) ? 24'hFF_FFFF : 24'd12001;
      f.onset = ONSET_W'($urandom);
      send_frame(f);
      if (k == 6) send_frame('{32'd7, 16'd0, 16'd0, 16'hFFFF, 24'h0, 16'd0});
    end
    // The closing frame is peaky but must not open a new note.
    send_frame('{32'hFFFF_FFFF, 16'd38000, 16'h1234, 16'h1000 + 16'd32, 24'hFF_FFFF, 16'h0});
    send_frame('{32'd200, 16'd0, 16'd0, 16'h2000, 24'd12001, 16'd0});
    send_frame('{32'd201, 16'd5897, 16'hFFFF, 16'h2000, 24'd12001, 16'd0});
    send_frame('{32'd202, 16'd5898, 16'd0, 16'h2000, 24'd12001, 16'd0});
    send_frame('{32'd203, 16'hFFFF, 16'd0, 16'h3000, 24'd5, 16'hFFFF});
    send_frame('{32'd204, 16'd100, 16'd0, 16'h0000, 24'hFF_FFFF, 16'h8000});
    send_frame('{32'd205, 16'd100, 16'd0, 16'd31, 24'hFF_FFFF, 16'h0});
    send_frame('{32'd206, 16'd100, 16'd0, 16'd0, 24'd12000, 16'h0});
  endtask

  initial begin
    cfg_set_t cfg;
    int quota;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    cfg_now = '{0, 16'hFFFF, 12000, 32, 5898, 10, 4};
    set_idling(IDLE_NONE);
    run_directed();

    for (int ph = 0; ph < 9; ph++) begin
      quiesce();
      quota = 200;
      case (ph)
        0: cfg = '{8000, 6000, 12000, 32, 5898, 10, 4};
        // Widest settings: every pitch but zero is in the window, every close emits.
        1: cfg = '{16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 0, 12'hFFF};
        // Empty window and an unreachable threshold: frames only advance the counter.
        3: begin
          cfg = '{0, 0, 24'hFF_FFFF, 0, 0, 12'hFFF, 0};
          quota = 40;
        end
        8: begin
          cfg = random_config();
          cfg.min_frames = 0;
        end
        default: cfg = random_config();
      endcase
      apply_config(cfg);
      set_idling(idle_mode_t'(ph % 4));
      run_random(quota);
    end

    quiesce();
    if (mismatch_count == 0 && notes_awaited == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
